// ----- design/three_body_gravity_acceleration_unit_defines.svh -----
// Assertion macros shared by the gravity unit checker.
`ifndef THREE_BODY_GRAVITY_ACCELERATION_UNIT_DEFINES_SVH
`define THREE_BODY_GRAVITY_ACCELERATION_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TBGA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbga: assertion failed");

// Next-cycle implication, disabled during reset.
`define TBGA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbga: assertion failed");

`endif

// ----- design/tbga_pkg.sv -----
// Shared constants and types of the three-body gravity unit.
package tbga_pkg;

    localparam int GM_WIDTH        = 32;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int CFG_ADDR_WIDTH  = 3;

    // G * m reset value, unsigned Q16.16
    localparam logic [GM_WIDTH-1:0] GM_RESET = 32'd437407;

    typedef enum logic [0:0] {
        REG_GM_PRODUCT = 1'b0
    } cfg_reg_t;

endpackage

// ----- design/tbga_pair.sv -----
// Pipelined acceleration term of one body pair: distance, square root, divide.
module tbga_pair #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [COORD_WIDTH-1:0] pos_i [3],
    input  logic [COORD_WIDTH-1:0] pos_j [3],
    input  logic [tbga_pkg::GM_WIDTH-1:0] gm,
    output logic                   term_valid,
    output logic [COORD_WIDTH-1:0] term [3],
    output logic                   hit
);

    localparam int CW  = COORD_WIDTH;
    localparam int DMW = CW + 1;                     // |d|
    localparam int R2W = 2 * CW + 2;                 // r2
    localparam int SW  = CW + 1;                     // isqrt(r2)
    localparam int RMW = SW + 3;                     // sqrt remainder
    localparam int PW  = tbga_pkg::GM_WIDTH + DMW;   // gm * |d|
    localparam int NW  = PW + 2 * FRAC_BITS;         // numerator
    localparam int DW  = R2W + SW;                   // r2 * s
    localparam int NHW = NW - CW;
    localparam int RW  = ((NHW > DW) ? NHW : DW) + 1;

    // ---------------- stage 1: differences ----------------
    logic           v1_reg;
    logic [DMW-1:0] mag1_reg [3];
    logic           pos1_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic [CW:0] diff;
            diff = {pos_i[k][CW-1], pos_i[k]} - {pos_j[k][CW-1], pos_j[k]};
            mag1_reg[k] <= diff[CW] ? (~diff + 1'b1) : diff;
            pos1_reg[k] <= !diff[CW] && (diff != '0);
        end
    end

    // ---------------- stage 2: squares and gm products ----------------
    logic           v2_reg;
    logic [R2W-1:0] sq2_reg  [3];
    logic [PW-1:0]  prod2_reg [3];
    logic           pos2_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            sq2_reg[k]   <= R2W'(mag1_reg[k]) * R2W'(mag1_reg[k]);
            prod2_reg[k] <= PW'(gm) * PW'(mag1_reg[k]);
            pos2_reg[k]  <= pos1_reg[k];
        end
    end

    // ---------------- stage 3: r2 ----------------
    logic           v3_reg;
    logic [R2W-1:0] r2_3_reg;
    logic           zero3_reg;
    logic [PW-1:0]  prod3_reg [3];
    logic           pos3_reg [3];
    logic [R2W-1:0] r2_next;

    assign r2_next = sq2_reg[0] + sq2_reg[1] + sq2_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        r2_3_reg  <= r2_next;
        zero3_reg <= (r2_next == '0);
        prod3_reg <= prod2_reg;
        pos3_reg  <= pos2_reg;
    end

    // ---------------- square root, one root bit per stage ----------------
    logic           sv   [SW+1];
    logic [R2W-1:0] sr2  [SW+1];
    logic [RMW-1:0] srem [SW+1];
    logic [SW-1:0]  sroot [SW+1];
    logic           szero [SW+1];
    logic [PW-1:0]  sprod [SW+1][3];
    logic           spos  [SW+1][3];

    assign sv[0]    = v3_reg;
    assign sr2[0]   = r2_3_reg;
    assign srem[0]  = '0;
    assign sroot[0] = '0;
    assign szero[0] = zero3_reg;
    assign sprod[0] = prod3_reg;
    assign spos[0]  = pos3_reg;

    for (genvar s = 0; s < SW; s++)
    begin : g_sqrt
        logic           v_reg;
        logic [R2W-1:0] r2_reg;
        logic [RMW-1:0] rem_reg;
        logic [SW-1:0]  root_reg;
        logic           zero_reg;
        logic [PW-1:0]  prod_reg [3];
        logic           pos_reg [3];
        logic [RMW-1:0] rem_sh;
        logic [RMW-1:0] trial;
        logic           ge;

        always_comb
        begin
            rem_sh = {srem[s][RMW-3:0], sr2[s][2*(SW-1-s)+1 -: 2]};
            trial  = {1'b0, sroot[s], 2'b01};
            ge     = (rem_sh >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else
            begin
                v_reg <= sv[s];
            end
        end

        always_ff @(posedge clk)
        begin
            r2_reg   <= sr2[s];
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {sroot[s][SW-2:0], ge};
            zero_reg <= szero[s];
            prod_reg <= sprod[s];
            pos_reg  <= spos[s];
        end

        assign sv[s+1]    = v_reg;
        assign sr2[s+1]   = r2_reg;
        assign srem[s+1]  = rem_reg;
        assign sroot[s+1] = root_reg;
        assign szero[s+1] = zero_reg;
        assign sprod[s+1] = prod_reg;
        assign spos[s+1]  = pos_reg;
    end

    // ---------------- r2 * s in two halves ----------------
    logic             vm1_reg;
    logic [2*SW-1:0]  pp_lo_reg;
    logic [2*SW-1:0]  pp_hi_reg;
    logic             zm1_reg;
    logic [PW-1:0]    prodm1_reg [3];
    logic             posm1_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm1_reg <= 1'b0;
        end
        else
        begin
            vm1_reg <= sv[SW];
        end
    end

    always_ff @(posedge clk)
    begin
        pp_lo_reg  <= (2*SW)'(sr2[SW][CW:0]) * (2*SW)'(sroot[SW]);
        pp_hi_reg  <= (2*SW)'(sr2[SW][R2W-1:CW+1]) * (2*SW)'(sroot[SW]);
        zm1_reg    <= szero[SW];
        prodm1_reg <= sprod[SW];
        posm1_reg  <= spos[SW];
    end

    logic           vm2_reg;
    logic [DW-1:0]  den_reg;
    logic           zm2_reg;
    logic [PW-1:0]  prodm2_reg [3];
    logic           posm2_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm2_reg <= 1'b0;
        end
        else
        begin
            vm2_reg <= vm1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg    <= (DW'(pp_hi_reg) << (CW + 1)) + DW'(pp_lo_reg);
        zm2_reg    <= zm1_reg;
        prodm2_reg <= prodm1_reg;
        posm2_reg  <= posm1_reg;
    end

    // ---------------- divider setup: overflow check ----------------
    logic          vd0_reg;
    logic [DW-1:0] dend0_reg;
    logic [RW-1:0] rem0_reg [3];
    logic [CW-1:0] nq0_reg  [3];
    logic          ovf0_reg [3];
    logic          pos0_reg [3];
    logic          zd0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vd0_reg <= 1'b0;
        end
        else
        begin
            vd0_reg <= vm2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic [NW-1:0] num;
            logic          ovf;
            num = {prodm2_reg[k], {(2*FRAC_BITS){1'b0}}};
            // quotient does not fit in CW bits
            ovf = (RW'(num[NW-1:CW]) >= RW'(den_reg));
            ovf0_reg[k] <= ovf;
            rem0_reg[k] <= ovf ? '0 : RW'(num[NW-1:CW]);
            nq0_reg[k]  <= num[CW-1:0];
        end
        dend0_reg <= den_reg;
        zd0_reg   <= zm2_reg;
        pos0_reg  <= posm2_reg;
    end

    // ---------------- restoring divide, one quotient bit per stage ----------------
    logic          dv   [CW+1];
    logic [DW-1:0] dden [CW+1];
    logic [RW-1:0] drem [CW+1][3];
    logic [CW-1:0] dnq  [CW+1][3];
    logic          dovf [CW+1][3];
    logic          dpos [CW+1][3];
    logic          dzero [CW+1];

    assign dv[0]    = vd0_reg;
    assign dden[0]  = dend0_reg;
    assign drem[0]  = rem0_reg;
    assign dnq[0]   = nq0_reg;
    assign dovf[0]  = ovf0_reg;
    assign dpos[0]  = pos0_reg;
    assign dzero[0] = zd0_reg;

    for (genvar t = 0; t < CW; t++)
    begin : g_div
        logic          v_reg;
        logic [DW-1:0] den_t_reg;
        logic [RW-1:0] rem_reg [3];
        logic [CW-1:0] nq_reg  [3];
        logic          ovf_reg [3];
        logic          pos_reg [3];
        logic          zero_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else
            begin
                v_reg <= dv[t];
            end
        end

        // numerator bits shift out of nq as quotient bits shift in
        always_ff @(posedge clk)
        begin
            for (int k = 0; k < 3; k++)
            begin
                logic [RW-1:0] rem_sh;
                logic          ge;
                rem_sh = {drem[t][k][RW-2:0], dnq[t][k][CW-1]};
                ge     = (rem_sh >= RW'(dden[t]));
                rem_reg[k] <= ge ? (rem_sh - RW'(dden[t])) : rem_sh;
                nq_reg[k]  <= {dnq[t][k][CW-2:0], ge};
            end
            den_t_reg <= dden[t];
            ovf_reg   <= dovf[t];
            pos_reg   <= dpos[t];
            zero_reg  <= dzero[t];
        end

        assign dv[t+1]    = v_reg;
        assign dden[t+1]  = den_t_reg;
        assign drem[t+1]  = rem_reg;
        assign dnq[t+1]   = nq_reg;
        assign dovf[t+1]  = ovf_reg;
        assign dpos[t+1]  = pos_reg;
        assign dzero[t+1] = zero_reg;
    end

    // ---------------- clamp and sign ----------------
    localparam logic [CW-1:0] LIMIT  = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] POS_HI = {1'b0, {(CW-1){1'b1}}};

    logic          tv_reg;
    logic [CW-1:0] term_reg [3];
    logic          hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_reg <= 1'b0;
        end
        else
        begin
            tv_reg <= dv[CW];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic [CW-1:0] mag;
            mag = (dovf[CW][k] || (dnq[CW][k] > LIMIT)) ? LIMIT : dnq[CW][k];
            if (dpos[CW][k])
            begin
                term_reg[k] <= ~mag + 1'b1;
            end
            else
            begin
                term_reg[k] <= (mag == LIMIT) ? POS_HI : mag;
            end
        end
        hit_reg <= dzero[CW];
    end

    assign term_valid = tv_reg;
    assign term       = term_reg;
    assign hit        = hit_reg;

endmodule

// ----- design/three_body_gravity_acceleration_unit.sv -----
// Three-body Newtonian acceleration pipeline, top level with register port.
//
// Accepts one transaction of nine body coordinates in every clock cycle; busy
// never rises. Results appear on the accel and coincident ports with done high
// for exactly one cycle. The pipeline depth comes mostly from the bit-per-stage
// square root (COORD_WIDTH+1 stages) and the restoring divider (COORD_WIDTH
// stages) of each pair unit. The receiver cannot stall; a result must be taken
// when done is high. gm_product lives at byte address 0 of the APB port and
// should be written only while no transaction is in flight.
module three_body_gravity_acceleration_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [COORD_WIDTH-1:0] body_a_x,
    input  logic [COORD_WIDTH-1:0] body_a_y,
    input  logic [COORD_WIDTH-1:0] body_a_z,
    input  logic [COORD_WIDTH-1:0] body_b_x,
    input  logic [COORD_WIDTH-1:0] body_b_y,
    input  logic [COORD_WIDTH-1:0] body_b_z,
    input  logic [COORD_WIDTH-1:0] body_c_x,
    input  logic [COORD_WIDTH-1:0] body_c_y,
    input  logic [COORD_WIDTH-1:0] body_c_z,
    output logic                   done,
    output logic [COORD_WIDTH-1:0] accel_a_x,
    output logic [COORD_WIDTH-1:0] accel_a_y,
    output logic [COORD_WIDTH-1:0] accel_a_z,
    output logic [COORD_WIDTH-1:0] accel_b_x,
    output logic [COORD_WIDTH-1:0] accel_b_y,
    output logic [COORD_WIDTH-1:0] accel_b_z,
    output logic [COORD_WIDTH-1:0] accel_c_x,
    output logic [COORD_WIDTH-1:0] accel_c_y,
    output logic [COORD_WIDTH-1:0] accel_c_z,
    output logic                   coincident,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [tbga_pkg::CFG_ADDR_WIDTH-1:0] paddr,
    input  logic [tbga_pkg::CFG_DATA_WIDTH-1:0] pwdata,
    output logic [tbga_pkg::CFG_DATA_WIDTH-1:0] prdata,
    output logic                   pready
);

    localparam int CW = COORD_WIDTH;

    localparam logic [CW+1:0] SUM_HI = {3'b000, {(CW-1){1'b1}}};
    localparam logic [CW+1:0] SUM_LO = {3'b111, {(CW-1){1'b0}}};

    function automatic logic [CW-1:0] sat_sum(input logic [CW+1:0] v);
        if ($signed(v) > $signed(SUM_HI))
        begin
            return SUM_HI[CW-1:0];
        end
        else if ($signed(v) < $signed(SUM_LO))
        begin
            return SUM_LO[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

    function automatic logic [CW+1:0] ext(input logic [CW-1:0] v);
        return {{2{v[CW-1]}}, v};
    endfunction

    // ---------------- configuration ----------------
    logic [tbga_pkg::GM_WIDTH-1:0] gm_reg;
    tbga_pkg::cfg_reg_t            cfg_sel;

    assign cfg_sel = tbga_pkg::cfg_reg_t'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gm_reg <= tbga_pkg::GM_RESET;
        end
        else if (psel && penable && pwrite && (cfg_sel == tbga_pkg::REG_GM_PRODUCT))
        begin
            gm_reg <= pwdata;
        end
    end

    always_comb
    begin
        case (cfg_sel)
            tbga_pkg::REG_GM_PRODUCT: prdata = gm_reg;
            default:                  prdata = '0;
        endcase
    end

    // ---------------- input capture ----------------
    logic          in_valid_reg;
    logic [CW-1:0] pa_reg [3];
    logic [CW-1:0] pb_reg [3];
    logic [CW-1:0] pc_reg [3];

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        pa_reg[0] <= body_a_x;
        pa_reg[1] <= body_a_y;
        pa_reg[2] <= body_a_z;
        pb_reg[0] <= body_b_x;
        pb_reg[1] <= body_b_y;
        pb_reg[2] <= body_b_z;
        pc_reg[0] <= body_c_x;
        pc_reg[1] <= body_c_y;
        pc_reg[2] <= body_c_z;
    end

    // ---------------- pair units ----------------
    logic          ab_valid, ac_valid, bc_valid;
    logic [CW-1:0] t_ab [3];
    logic [CW-1:0] t_ac [3];
    logic [CW-1:0] t_bc [3];
    logic          hit_ab, hit_ac, hit_bc;

    tbga_pair #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_pair_ab (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid_reg),
        .pos_i(pa_reg), .pos_j(pb_reg), .gm(gm_reg),
        .term_valid(ab_valid), .term(t_ab), .hit(hit_ab)
    );

    tbga_pair #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_pair_ac (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid_reg),
        .pos_i(pa_reg), .pos_j(pc_reg), .gm(gm_reg),
        .term_valid(ac_valid), .term(t_ac), .hit(hit_ac)
    );

    tbga_pair #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_pair_bc (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid_reg),
        .pos_i(pb_reg), .pos_j(pc_reg), .gm(gm_reg),
        .term_valid(bc_valid), .term(t_bc), .hit(hit_bc)
    );

    // ---------------- combine and saturate ----------------
    logic          done_reg;
    logic [CW-1:0] acc_reg [9];
    logic          coincident_reg;
    logic          any_hit;

    assign any_hit = hit_ab || hit_ac || hit_bc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ab_valid && ac_valid && bc_valid;
        end
    end

    // partner body takes the pair term with opposite sign
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            acc_reg[k]     <= any_hit ? '0 : sat_sum(ext(t_ab[k]) + ext(t_ac[k]));
            acc_reg[3 + k] <= any_hit ? '0 : sat_sum(ext(t_bc[k]) - ext(t_ab[k]));
            acc_reg[6 + k] <= any_hit ? '0 : sat_sum('0 - ext(t_ac[k]) - ext(t_bc[k]));
        end
        coincident_reg <= any_hit;
    end

    assign done       = done_reg;
    assign accel_a_x  = acc_reg[0];
    assign accel_a_y  = acc_reg[1];
    assign accel_a_z  = acc_reg[2];
    assign accel_b_x  = acc_reg[3];
    assign accel_b_y  = acc_reg[4];
    assign accel_b_z  = acc_reg[5];
    assign accel_c_x  = acc_reg[6];
    assign accel_c_y  = acc_reg[7];
    assign accel_c_z  = acc_reg[8];
    assign coincident = coincident_reg;

endmodule

// ----- design/tbga_checker.sv -----
// Port-level checks of the gravity unit, bound to the top level.
`include "three_body_gravity_acceleration_unit_defines.svh"

module tbga_checker #(
    parameter int COORD_WIDTH = 32,
    parameter int LATENCY     = 74
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   done,
    input logic                   coincident,
    input logic [COORD_WIDTH-1:0] accel_a_x,
    input logic [COORD_WIDTH-1:0] accel_a_y,
    input logic [COORD_WIDTH-1:0] accel_a_z,
    input logic [COORD_WIDTH-1:0] accel_b_x,
    input logic [COORD_WIDTH-1:0] accel_b_y,
    input logic [COORD_WIDTH-1:0] accel_b_z,
    input logic [COORD_WIDTH-1:0] accel_c_x,
    input logic [COORD_WIDTH-1:0] accel_c_y,
    input logic [COORD_WIDTH-1:0] accel_c_z
);

    logic accel_zero;

    assign accel_zero = (accel_a_x == '0) && (accel_a_y == '0) && (accel_a_z == '0)
                     && (accel_b_x == '0) && (accel_b_y == '0) && (accel_b_z == '0)
                     && (accel_c_x == '0) && (accel_c_y == '0) && (accel_c_z == '0);

    // every accepted transaction is followed by one result with done high
    `TBGA_ASSERT_NEXT(a_result_follows, clk, rst_n, start && !busy, ##(LATENCY-1) done)

    // no result without an earlier accepted transaction
    `TBGA_ASSERT_IMP(a_result_has_source, clk, rst_n, done, $past(start && !busy, LATENCY))

    // coincident bodies force all accelerations to zero
    `TBGA_ASSERT_IMP(a_coincident_zero, clk, rst_n, done && coincident, accel_zero)

endmodule

bind three_body_gravity_acceleration_unit tbga_checker #(
    .COORD_WIDTH(COORD_WIDTH),
    .LATENCY(2 * COORD_WIDTH + 10)
) u_tbga_checker (.*);
